@@ hdl/fme_pkg.sv @@
// shared types, constants and exponent table of the fuzzy membership evaluator
package fme_pkg;

  localparam int EXP_TABLE_ENTRIES = 1024;
  localparam int QW = $clog2(EXP_TABLE_ENTRIES);
  localparam int GDIV_STAGES = 5;
  localparam int GBITS = (QW + GDIV_STAGES - 1) / GDIV_STAGES;
  localparam int GRW = 48;
  localparam int RDIV_STAGES = 8;
  localparam int RBITS = 16 / RDIV_STAGES;
  localparam int PIPE_DEPTH = 10;
  localparam logic [16:0] GRADE_ONE = 17'h10000;

  // series terms of exp(-1/64) in q4.60, each the previous over 64*n, the eighth is zero
  localparam logic [63:0] EXP_ONE   = 64'd1 << 60;
  localparam logic [63:0] EXP_T1    = EXP_ONE / 64'd64;
  localparam logic [63:0] EXP_T2    = EXP_T1 / 64'd128;
  localparam logic [63:0] EXP_T3    = EXP_T2 / 64'd192;
  localparam logic [63:0] EXP_T4    = EXP_T3 / 64'd256;
  localparam logic [63:0] EXP_T5    = EXP_T4 / 64'd320;
  localparam logic [63:0] EXP_T6    = EXP_T5 / 64'd384;
  localparam logic [63:0] EXP_T7    = EXP_T6 / 64'd448;
  localparam logic [63:0] EXP_STEP  = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                      - EXP_T5 + EXP_T6 - EXP_T7;

  typedef enum logic [1:0] {
    GRADE_ZERO,
    GRADE_FULL,
    GRADE_RAMP
  } grade_kind_e;

  typedef enum logic [2:0] {
    REG_LEFT_FOOT,
    REG_PEAK,
    REG_RIGHT_FOOT,
    REG_SHOULDER_LEFT,
    REG_SHOULDER_RIGHT,
    REG_CENTER,
    REG_SIGMA
  } reg_idx_e;

  typedef struct packed {
    grade_kind_e     tri_kind;
    grade_kind_e     trap_kind;
    logic [15:0]     tri_num;
    logic [15:0]     tri_den;
    logic [15:0]     trap_num;
    logic [15:0]     trap_den;
    logic            sig_zero;
    logic            mag_zero;
    logic [15:0]     mag;
    logic [14:0]     sig;
    logic [31:0]     mag_sq;
    logic [29:0]     sig_sq;
    logic            sat;
    logic [GRW-1:0]  g_rem;
    logic [29:0]     g_den;
    logic [QW-1:0]   g_q;
  } pipe_t;

  typedef logic [16:0] exp_tab_t [EXP_TABLE_ENTRIES];

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] bh;
    logic [63:0] bl;
    logic [63:0] mid;
    logic [63:0] rnd;
    r = EXP_STEP;
    v = EXP_ONE;
    for (int k = 0; k < EXP_TABLE_ENTRIES; k++) begin
      rnd    = (v + (64'd1 << 43)) >> 44;
      tab[k] = rnd[16:0];
      ah  = v >> 32;
      al  = v & 64'hFFFF_FFFF;
      bh  = r >> 32;
      bl  = r & 64'hFFFF_FFFF;
      mid = ah * bl + al * bh + ((al * bl) >> 32);
      v   = ((ah * bh) << 4) + (mid >> 28);
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

@@ hdl/fuzzy_membership_evaluator_top.sv @@
// fuzzy membership evaluator top level: configuration registers and grade pipeline
// throughput: one sample per cycle unless the output stalls, set by the 8 two-bit stages of the ramp dividers
// a stalled output holds the last stage; empty stages ahead of it still fill
// reset: asynchronous active low, clears valid bits and loads register defaults
// no clearing pass after reset, the exponent table is a constant rom
module fuzzy_membership_evaluator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] tri_grade_o,
  output logic [16:0] trap_grade_o,
  output logic [16:0] gauss_grade_o
);

  localparam int D = fme_pkg::PIPE_DEPTH;

  logic signed [15:0] left_foot_q, peak_q, right_foot_q, shl_q, shr_q, center_q;
  logic [14:0]        sigma_q;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_foot_q  <= 16'sd0;
      peak_q       <= 16'sd256;
      right_foot_q <= 16'sd512;
      shl_q        <= 16'sd128;
      shr_q        <= 16'sd384;
      center_q     <= 16'sd256;
      sigma_q      <= 15'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        fme_pkg::REG_LEFT_FOOT:      left_foot_q  <= pwdata[15:0];
        fme_pkg::REG_PEAK:           peak_q       <= pwdata[15:0];
        fme_pkg::REG_RIGHT_FOOT:     right_foot_q <= pwdata[15:0];
        fme_pkg::REG_SHOULDER_LEFT:  shl_q        <= pwdata[15:0];
        fme_pkg::REG_SHOULDER_RIGHT: shr_q        <= pwdata[15:0];
        fme_pkg::REG_CENTER:         center_q     <= pwdata[15:0];
        fme_pkg::REG_SIGMA:          sigma_q      <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      fme_pkg::REG_LEFT_FOOT:      prdata = {16'd0, left_foot_q};
      fme_pkg::REG_PEAK:           prdata = {16'd0, peak_q};
      fme_pkg::REG_RIGHT_FOOT:     prdata = {16'd0, right_foot_q};
      fme_pkg::REG_SHOULDER_LEFT:  prdata = {16'd0, shl_q};
      fme_pkg::REG_SHOULDER_RIGHT: prdata = {16'd0, shr_q};
      fme_pkg::REG_CENTER:         prdata = {16'd0, center_q};
      fme_pkg::REG_SIGMA:          prdata = {17'd0, sigma_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // stage enables and valid bits
  logic [D-1:0] v_q;
  logic [D-1:0] en;

  always_comb begin
    en[D-1] = !v_q[D-1] || out_ready_i;
    for (int k = D - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[D-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < D; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  // datapath stages
  fme_pkg::pipe_t p_q [D-1];
  fme_pkg::pipe_t p_d [D-1];

  always_comb begin
    logic signed [16:0] x, a, b, c, d, dif;
    logic [16:0]        amag;
    logic [fme_pkg::GRW-1:0] r, dv;
    logic [fme_pkg::QW-1:0]  qv;
    int                      bi;

    x = 17'(signed'(sample_i));
    p_d[0] = '0;

    // triangle
    a = 17'(left_foot_q);
    b = 17'(peak_q);
    c = 17'(right_foot_q);
    if (x <= a || x >= c) begin
      p_d[0].tri_kind = fme_pkg::GRADE_ZERO;
    end else if (x == b) begin
      p_d[0].tri_kind = fme_pkg::GRADE_FULL;
    end else if (x < b) begin
      p_d[0].tri_kind = fme_pkg::GRADE_RAMP;
      p_d[0].tri_num  = 16'(x - a);
      p_d[0].tri_den  = 16'(b - a);
    end else begin
      p_d[0].tri_kind = fme_pkg::GRADE_RAMP;
      p_d[0].tri_num  = 16'(c - x);
      p_d[0].tri_den  = 16'(c - b);
    end

    // trapezoid
    b = 17'(shl_q);
    c = 17'(shr_q);
    d = 17'(right_foot_q);
    if (x <= a || x >= d) begin
      p_d[0].trap_kind = fme_pkg::GRADE_ZERO;
    end else if (x >= b && x <= c) begin
      p_d[0].trap_kind = fme_pkg::GRADE_FULL;
    end else if (x < b) begin
      p_d[0].trap_kind = fme_pkg::GRADE_RAMP;
      p_d[0].trap_num  = 16'(x - a);
      p_d[0].trap_den  = 16'(b - a);
    end else begin
      p_d[0].trap_kind = fme_pkg::GRADE_RAMP;
      p_d[0].trap_num  = 16'(d - x);
      p_d[0].trap_den  = 16'(d - c);
    end

    // gaussian distance
    dif  = x - 17'(center_q);
    amag = dif[16] ? 17'(-dif) : 17'(dif);
    p_d[0].mag      = amag[15:0];
    p_d[0].sig      = sigma_q;
    p_d[0].sig_zero = (sigma_q == 15'd0);

    for (int k = 1; k < D - 1; k++) begin
      p_d[k] = p_q[k-1];
    end

    // squares
    p_d[1].mag_sq   = p_q[0].mag * p_q[0].mag;
    p_d[1].sig_sq   = p_q[0].sig * p_q[0].sig;
    p_d[1].mag_zero = (p_q[0].mag == 16'd0);

    // range check against the table size
    p_d[2].g_rem = fme_pkg::GRW'(p_q[1].mag_sq) << 5;
    p_d[2].g_den = p_q[1].sig_sq;
    p_d[2].g_q   = '0;
    p_d[2].sat   = (fme_pkg::GRW'(p_q[1].mag_sq) << 5)
                   >= (fme_pkg::GRW'(p_q[1].sig_sq) << fme_pkg::QW);

    // exponent index division
    for (int s = 0; s < fme_pkg::GDIV_STAGES; s++) begin
      r  = p_q[s+2].g_rem;
      qv = p_q[s+2].g_q;
      for (int t = 0; t < fme_pkg::GBITS; t++) begin
        bi = fme_pkg::QW - 1 - s * fme_pkg::GBITS - t;
        if (bi >= 0) begin
          dv = fme_pkg::GRW'(p_q[s+2].g_den) << bi;
          if (r >= dv) begin
            r      = r - dv;
            qv[bi] = 1'b1;
          end
        end
      end
      p_d[s+3].g_rem = r;
      p_d[s+3].g_q   = qv;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < D - 1; k++) begin
      if (en[k]) begin
        p_q[k] <= p_d[k];
      end
    end
  end

  // exponent rom, registered read
  logic [16:0] rom_q;

  always_ff @(posedge clk_i) begin
    if (en[D-2]) begin
      rom_q <= fme_pkg::ExpTab[p_q[D-3].g_q];
    end
  end

  // ramp dividers
  logic [15:0] tri_quo, trap_quo;

  fme_ramp_div u_tri_div (
    .clk_i (clk_i),
    .en_i  (en[fme_pkg::RDIV_STAGES:1]),
    .num_i (p_q[0].tri_num),
    .den_i (p_q[0].tri_den),
    .quo_o (tri_quo)
  );

  fme_ramp_div u_trap_div (
    .clk_i (clk_i),
    .en_i  (en[fme_pkg::RDIV_STAGES:1]),
    .num_i (p_q[0].trap_num),
    .den_i (p_q[0].trap_den),
    .quo_o (trap_quo)
  );

  // output register
  logic [16:0] tri_d, trap_d, gauss_d;
  logic [16:0] tri_q, trap_q, gauss_q;

  always_comb begin
    unique case (p_q[D-2].tri_kind)
      fme_pkg::GRADE_FULL: tri_d = fme_pkg::GRADE_ONE;
      fme_pkg::GRADE_RAMP: tri_d = {1'b0, tri_quo};
      default:             tri_d = 17'd0;
    endcase
    unique case (p_q[D-2].trap_kind)
      fme_pkg::GRADE_FULL: trap_d = fme_pkg::GRADE_ONE;
      fme_pkg::GRADE_RAMP: trap_d = {1'b0, trap_quo};
      default:             trap_d = 17'd0;
    endcase
    if (p_q[D-2].sig_zero) begin
      gauss_d = p_q[D-2].mag_zero ? fme_pkg::GRADE_ONE : 17'd0;
    end else if (p_q[D-2].sat) begin
      gauss_d = 17'd0;
    end else begin
      gauss_d = rom_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[D-1]) begin
      tri_q   <= tri_d;
      trap_q  <= trap_d;
      gauss_q <= gauss_d;
    end
  end

  assign tri_grade_o   = tri_q;
  assign trap_grade_o  = trap_q;
  assign gauss_grade_o = gauss_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q))
    else $error("input stalled with an empty stage");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[D-2] && en[D-1]) |=> out_valid_o)
    else $error("item lost at the output register");

  a_grade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tri_grade_o <= fme_pkg::GRADE_ONE && trap_grade_o <= fme_pkg::GRADE_ONE
                     && gauss_grade_o <= fme_pkg::GRADE_ONE))
    else $error("grade above one");

endmodule

@@ hdl/fme_ramp_div.sv @@
// pipelined restoring divider for the flank ramps, quotient of (num << 16) / den
module fme_ramp_div (
  input  logic                               clk_i,
  input  logic [fme_pkg::RDIV_STAGES-1:0]    en_i,
  input  logic [15:0]                        num_i,
  input  logic [15:0]                        den_i,
  output logic [15:0]                        quo_o
);

  logic [15:0] rem_q [fme_pkg::RDIV_STAGES];
  logic [15:0] den_q [fme_pkg::RDIV_STAGES];
  logic [15:0] quo_q [fme_pkg::RDIV_STAGES];
  logic [15:0] rem_d [fme_pkg::RDIV_STAGES];
  logic [15:0] quo_d [fme_pkg::RDIV_STAGES];

  always_comb begin
    logic [15:0] r;
    logic [15:0] d;
    logic [15:0] qv;
    logic [16:0] t;
    for (int s = 0; s < fme_pkg::RDIV_STAGES; s++) begin
      if (s == 0) begin
        r  = num_i;
        d  = den_i;
        qv = 16'd0;
      end else begin
        r  = rem_q[s-1];
        d  = den_q[s-1];
        qv = quo_q[s-1];
      end
      for (int b = 0; b < fme_pkg::RBITS; b++) begin
        t  = {r, 1'b0};
        qv = {qv[14:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t     = t - {1'b0, d};
          qv[0] = 1'b1;
        end
        r = t[15:0];
      end
      rem_d[s] = r;
      quo_d[s] = qv;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < fme_pkg::RDIV_STAGES; s++) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= (s == 0) ? den_i : den_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[fme_pkg::RDIV_STAGES-1];

endmodule

@@ tb/fuzzy_membership_evaluator_checker.sv @@
// checker for the fuzzy membership evaluator: grade predictor, result store and comparison
module fuzzy_membership_evaluator_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [15:0] sample_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [16:0] tri_grade_i,
  input  logic [16:0] trap_grade_i,
  input  logic [16:0] gauss_grade_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [16:0] tri_g;
    logic [16:0] trap_g;
    logic [16:0] gauss_g;
  } grades_t;

  logic [16:0] exp_rom [fme_pkg::EXP_TABLE_ENTRIES];
  logic [15:0] left_q, peak_q, right_q, shl_q, shr_q, center_q;
  logic [14:0] sigma_q;
  grades_t     grade_queue[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = grade_queue.size();

  function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
    longint unsigned ah, al, bh, bl, mid;
    ah  = a >> 32;
    al  = a & 64'hFFFF_FFFF;
    bh  = b >> 32;
    bl  = b & 64'hFFFF_FFFF;
    mid = ah * bl + al * bh + ((al * bl) >> 32);
    return ((ah * bh) << 4) + (mid >> 28);
  endfunction

  initial begin
    longint unsigned step_r, term, acc;
    step_r = 64'd1 << 60;
    term   = 64'd1 << 60;
    acc    = 64'd1 << 60;
    for (int n = 1; n < 40; n++) begin
      term = term / (64 * n);
      if (term == 0) break;
      if (n % 2) step_r -= term;
      else step_r += term;
    end
    for (int k = 0; k < fme_pkg::EXP_TABLE_ENTRIES; k++) begin
      exp_rom[k] = 17'((acc + (64'd1 << 43)) >> 44);
      acc = mul_q60(acc, step_r);
    end
  end

  function automatic logic [16:0] flank(longint num, longint den);
    return 17'((longint'(num) << 16) / den);
  endfunction

  function automatic grades_t grade_sample(logic [15:0] s);
    grades_t g;
    longint  x, a, b, c, d;
    longint unsigned mag, den, q;
    x = longint'(signed'(s));
    a = longint'(signed'(left_q));
    d = longint'(signed'(right_q));
    b = longint'(signed'(peak_q));
    if (x <= a || x >= d) g.tri_g = '0;
    else if (x == b) g.tri_g = fme_pkg::GRADE_ONE;
    else if (x < b) g.tri_g = flank(x - a, b - a);
    else g.tri_g = flank(d - x, d - b);
    b = longint'(signed'(shl_q));
    c = longint'(signed'(shr_q));
    if (x <= a || x >= d) g.trap_g = '0;
    else if (x >= b && x <= c) g.trap_g = fme_pkg::GRADE_ONE;
    else if (x < b) g.trap_g = flank(x - a, b - a);
    else g.trap_g = flank(d - x, d - c);
    c   = x - longint'(signed'(center_q));
    mag = (c < 0) ? -c : c;
    if (sigma_q == 0) begin
      g.gauss_g = (mag == 0) ? fme_pkg::GRADE_ONE : '0;
    end else begin
      den = 2 * longint'(sigma_q) * longint'(sigma_q);
      q   = (mag * mag * 64) / den;
      g.gauss_g = (q >= fme_pkg::EXP_TABLE_ENTRIES) ? '0 : exp_rom[q];
    end
    return g;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    grades_t want;
    if (!rst_ni) begin
      left_q   <= 16'd0;
      peak_q   <= 16'd256;
      right_q  <= 16'd512;
      shl_q    <= 16'd128;
      shr_q    <= 16'd384;
      center_q <= 16'd256;
      sigma_q  <= 15'd256;
      fails    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          fme_pkg::REG_LEFT_FOOT:      left_q   <= pwdata[15:0];
          fme_pkg::REG_PEAK:           peak_q   <= pwdata[15:0];
          fme_pkg::REG_RIGHT_FOOT:     right_q  <= pwdata[15:0];
          fme_pkg::REG_SHOULDER_LEFT:  shl_q    <= pwdata[15:0];
          fme_pkg::REG_SHOULDER_RIGHT: shr_q    <= pwdata[15:0];
          fme_pkg::REG_CENTER:         center_q <= pwdata[15:0];
          fme_pkg::REG_SIGMA:          sigma_q  <= pwdata[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) grade_queue.push_back(grade_sample(sample_i));
      if (out_valid_i && out_ready_i) begin
        if (grade_queue.size() == 0) begin
          if (fails < 10) $display("unexpected result transfer: tri %0d trap %0d gauss %0d",
                                   tri_grade_i, trap_grade_i, gauss_grade_i);
          fails <= fails + 1;
        end else begin
          want = grade_queue.pop_front();
          if (want.tri_g !== tri_grade_i || want.trap_g !== trap_grade_i ||
              want.gauss_g !== gauss_grade_i) begin
            if (fails < 10)
              $display("grade mismatch: expected tri %0d trap %0d gauss %0d, got %0d %0d %0d",
                       want.tri_g, want.trap_g, want.gauss_g,
                       tri_grade_i, trap_grade_i, gauss_grade_i);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/fuzzy_membership_evaluator_top_test.sv @@
// stimulus, register setup and verdict for the fuzzy membership evaluator
module fuzzy_membership_evaluator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] sample = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] tri_grade, trap_grade, gauss_grade;
  int          fail_count, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0, quiet = 0;
  logic [15:0] corner [7];

  fuzzy_membership_evaluator_top dut (
    .clk_i(clk), .rst_ni(rst_n), .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready, .in_valid_i(in_valid), .in_ready_o(in_ready), .sample_i(sample),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .tri_grade_o(tri_grade),
    .trap_grade_o(trap_grade), .gauss_grade_o(gauss_grade)
  );

  fuzzy_membership_evaluator_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .sample_i(sample),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .tri_grade_i(tri_grade),
    .trap_grade_i(trap_grade), .gauss_grade_i(gauss_grade),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [4:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_reg(fme_pkg::reg_idx_e idx, logic [15:0] v);
    corner[idx] = (idx == fme_pkg::REG_SIGMA) ? {1'b0, v[14:0]} : v;
    reg_write({idx, 2'b00}, {16'($urandom), v});
  endtask

  task automatic send(logic [15:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (14) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(3);
    if (r == 0) return 16'($urandom);
    if (r == 1) return corner[$urandom_range(5)] + 16'($urandom_range(6)) - 16'd3;
    if (r == 2) return corner[$urandom_range(5)] + 16'($urandom_range(600)) - 16'd300;
    return corner[fme_pkg::REG_CENTER]
           + 16'($urandom_range(2 * corner[fme_pkg::REG_SIGMA] * 4 + 2))
           - 16'(corner[fme_pkg::REG_SIGMA] * 4 + 1);
  endfunction

  task automatic random_setting();
    int a, sl, pk, sr, d;
    a  = $urandom_range(62000) - 32768;
    sl = a + $urandom_range(400);
    sr = sl + $urandom_range(600);
    pk = $urandom_range(1) ? sl + $urandom_range(sr - sl) : a + $urandom_range(1200);
    d  = sr + $urandom_range(500);
    if ($urandom_range(5) == 0) begin
      sl = $urandom_range(65535);
      pk = $urandom_range(65535);
    end
    set_reg(fme_pkg::REG_LEFT_FOOT, 16'(a));
    set_reg(fme_pkg::REG_SHOULDER_LEFT, 16'(sl));
    set_reg(fme_pkg::REG_PEAK, 16'(pk));
    set_reg(fme_pkg::REG_SHOULDER_RIGHT, 16'(sr));
    set_reg(fme_pkg::REG_RIGHT_FOOT, 16'(d));
    set_reg(fme_pkg::REG_CENTER, 16'($urandom_range(1) ? $urandom : a + $urandom_range(1000)));
    case ($urandom_range(3))
      0: set_reg(fme_pkg::REG_SIGMA, 16'($urandom_range(32767)));
      1: set_reg(fme_pkg::REG_SIGMA, 16'($urandom_range(3)));
      default: set_reg(fme_pkg::REG_SIGMA, 16'($urandom_range(1, 600)));
    endcase
  endtask

  initial begin
    logic [15:0] directed [$];
    corner = '{16'd0, 16'd256, 16'd512, 16'd128, 16'd384, 16'd256, 16'd256};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    directed = '{16'h8000, 16'h7FFF, 16'd0, 16'd1, 16'hFFFF, 16'd255, 16'd256, 16'd257,
                 16'd127, 16'd128, 16'd129, 16'd383, 16'd384, 16'd385, 16'd511, 16'd512,
                 16'd513, 16'd64, 16'd448, 16'd300, 16'd200};
    foreach (directed[i]) send(directed[i]);
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct  = (ph % 4 == 1) ? 48 : (ph % 4 == 3) ? 6 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 48 : (ph % 4 == 3) ? 6 : 0;
      drain();
      case (ph)
        0: ;
        1: begin
          set_reg(fme_pkg::REG_LEFT_FOOT, 16'h8000);
          set_reg(fme_pkg::REG_PEAK, 16'h7FFF);
          set_reg(fme_pkg::REG_RIGHT_FOOT, 16'h7FFF);
          set_reg(fme_pkg::REG_SHOULDER_LEFT, 16'h8000);
          set_reg(fme_pkg::REG_SHOULDER_RIGHT, 16'h7FFF);
          set_reg(fme_pkg::REG_CENTER, 16'h8000);
          set_reg(fme_pkg::REG_SIGMA, 16'h7FFF);
          reg_write(5'd28, $urandom);
        end
        2: begin
          set_reg(fme_pkg::REG_LEFT_FOOT, 16'd100);
          set_reg(fme_pkg::REG_PEAK, 16'd50);
          set_reg(fme_pkg::REG_RIGHT_FOOT, 16'd90);
          set_reg(fme_pkg::REG_SHOULDER_LEFT, 16'hFF00);
          set_reg(fme_pkg::REG_SHOULDER_RIGHT, 16'd200);
          set_reg(fme_pkg::REG_CENTER, 16'd0);
          set_reg(fme_pkg::REG_SIGMA, 16'd0);
        end
        4: begin
          set_reg(fme_pkg::REG_SIGMA, 16'd1);
          set_reg(fme_pkg::REG_CENTER, 16'h7FFF);
          set_reg(fme_pkg::REG_PEAK, 16'h8000);
        end
        default: random_setting();
      endcase
      if (ph == 3) hold_cycles = 400;
      for (int i = 0; i < 228; i++) begin
        if (ph >= 5 && i % 76 == 75) begin
          drain();
          random_setting();
        end
        send(pick_sample());
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/fme_pkg.sv
hdl/fme_ramp_div.sv
hdl/fuzzy_membership_evaluator_top.sv
tb/fuzzy_membership_evaluator_checker.sv
tb/fuzzy_membership_evaluator_top_test.sv
